FILE: hw/rtl/node_element_incidence_table_top_defines.svh
// assertion helpers for the incidence table
`ifndef NODE_ELEMENT_INCIDENCE_TABLE_TOP_DEFINES_SVH
`define NODE_ELEMENT_INCIDENCE_TABLE_TOP_DEFINES_SVH

// checked only out of reset
`define NEI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NEI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/nei_pkg.sv
package nei_pkg;

  localparam int unsigned MAX_NODES_DEF   = 256;
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam int unsigned OPC_W  = 3;
  localparam int unsigned NODE_W = 9;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned STAT_W = 3;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(256);

  localparam logic [OPC_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPC_W-1:0] OP_SET    = 3'd1;
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OPC_W-1:0] OP_READ   = 3'd3;
  localparam logic [OPC_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_NODE = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD_B, S_RD_E, S_RD_T, S_DECIDE, S_SCAN_RD, S_SCAN_CMP,
    S_INS, S_SH_RD, S_SH_WR, S_PUT, S_INC_RD, S_INC_WR, S_RD_V, S_RESP
  } state_t;

endpackage

FILE: hw/rtl/nei_in_if.sv
interface nei_in_if;
  logic                          valid;
  logic                          ready;
  logic [nei_pkg::OPC_W-1:0]     opcode;
  logic [nei_pkg::NODE_W-1:0]    node_number;
  logic [nei_pkg::POS_W-1:0]     position;
  logic [nei_pkg::ELEM_W-1:0]    elem_number;
  modport source (output valid, opcode, node_number, position, elem_number, input ready);
  modport sink   (input valid, opcode, node_number, position, elem_number, output ready);
endinterface

FILE: hw/rtl/nei_out_if.sv
interface nei_out_if;
  logic                          valid;
  logic                          ready;
  logic [nei_pkg::STAT_W-1:0]    status;
  logic [nei_pkg::ELEM_W-1:0]    elem_value;
  logic [nei_pkg::POS_W-1:0]     elem_count;
  modport source (output valid, status, elem_value, elem_count, input ready);
  modport sink   (input valid, status, elem_value, elem_count, output ready);
endinterface

FILE: hw/rtl/node_element_incidence_table_top.sv
// Node to element incidence table, compressed-row form. Offsets live in one
// synchronous memory of MAX_NODES+1 words and the element lists end to end in a
// second memory of MAX_ENTRIES words; one item is worked at a time and its
// result beat sits in an output register. Count, set in place, read and bad
// position make three offset reads, and bad node goes straight to the response;
// append first scans the list for a duplicate; any insertion moves the store
// entries above it up one place and then raises each offset from the node to
// the last active node. Clear, a write of node_count and reset each run a
// zeroing pass over all MAX_NODES+1 words of the offset memory, with
// in_if.ready low; node_count writes are taken at once.
`include "node_element_incidence_table_top_defines.svh"

module node_element_incidence_table_top #(
  parameter int unsigned MAX_NODES   = nei_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_ENTRIES = nei_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nei_in_if.sink                       in_if,
  nei_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [nei_pkg::NODE_W-1:0]   cfg_wdata
);

  localparam int unsigned NW = $clog2(MAX_NODES + 1);   // offset memory address
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1); // offset value
  localparam int unsigned AW = $clog2(MAX_ENTRIES);     // store address
  localparam int unsigned EW = nei_pkg::ELEM_W;

  // memories
  logic [OW-1:0] off_mem [MAX_NODES+1];
  logic [EW-1:0] st_mem  [MAX_ENTRIES];

  logic          off_we, off_re;
  logic [NW-1:0] off_waddr, off_raddr;
  logic [OW-1:0] off_wdata, off_rdata_r;
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [EW-1:0] st_wdata, st_rdata_r;

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    if (off_re) begin
      off_rdata_r <= off_mem[off_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_r <= st_mem[st_raddr];
    end
  end

  // control and item registers
  nei_pkg::state_t state_r, state_nxt;
  logic [nei_pkg::NODE_W-1:0] node_count_r;
  logic          clr_resp_r, clr_resp_nxt;
  logic [nei_pkg::OPC_W-1:0]  op_r, op_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [nei_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [EW-1:0] elem_r, elem_nxt;
  logic [OW-1:0] base_r, base_nxt;
  logic [OW-1:0] cnt_r, cnt_nxt;
  logic [OW-1:0] total_r, total_nxt;
  logic [OW-1:0] at_r, at_nxt;
  logic [OW-1:0] idx_r, idx_nxt;     // store walk: scan index or shift target
  logic [NW-1:0] kidx_r, kidx_nxt;   // offset walk
  logic [nei_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [EW-1:0] val_r, val_nxt;
  logic          out_valid_r;
  logic [nei_pkg::STAT_W-1:0] out_stat_r;
  logic [EW-1:0] out_val_r;
  logic [nei_pkg::POS_W-1:0]  out_cnt_r;

  // effective node count, clamped to the offset memory
  logic [31:0] nc32, act32, in_n32, pos32, cnt32, at32;
  logic [NW-1:0] act;
  logic          in_bad_node, accept, out_free, insert_op;

  assign nc32   = 32'(node_count_r);
  assign act32  = (nc32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : nc32;
  assign act    = act32[NW-1:0];
  assign in_n32 = 32'(in_if.node_number);
  assign in_bad_node = (in_n32 == 32'd0) || (in_n32 > act32);
  assign pos32  = 32'(pos_r);
  assign cnt32  = 32'(cnt_r);
  assign at32   = 32'(base_r) + ((op_r == nei_pkg::OP_APPEND) ? cnt32 : pos32);

  assign in_if.ready = (state_r == nei_pkg::S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // a new element goes in for append, set at the list end and insert at or below the list end
  assign insert_op = (op_r == nei_pkg::OP_APPEND)
                  || ((op_r == nei_pkg::OP_SET) && (pos32 == cnt32))
                  || ((op_r == nei_pkg::OP_INSERT) && (pos32 <= cnt32));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nei_pkg::S_CLR: begin
        if (32'(kidx_r) == 32'(MAX_NODES)) begin
          state_nxt = clr_resp_r ? nei_pkg::S_RESP : nei_pkg::S_IDLE;
        end
      end
      nei_pkg::S_IDLE: begin
        if (accept) begin
          if (in_if.opcode == nei_pkg::OP_CLEAR) state_nxt = nei_pkg::S_CLR;
          else if (in_bad_node)                  state_nxt = nei_pkg::S_RESP;
          else                                   state_nxt = nei_pkg::S_RD_B;
        end
      end
      nei_pkg::S_RD_B:  state_nxt = nei_pkg::S_RD_E;
      nei_pkg::S_RD_E:  state_nxt = nei_pkg::S_RD_T;
      nei_pkg::S_RD_T:  state_nxt = nei_pkg::S_DECIDE;
      nei_pkg::S_DECIDE: begin
        if (op_r == nei_pkg::OP_APPEND) begin
          state_nxt = (cnt_r == '0) ? nei_pkg::S_INS : nei_pkg::S_SCAN_RD;
        end else if (insert_op) begin
          state_nxt = nei_pkg::S_INS;
        end else if ((op_r == nei_pkg::OP_READ) && (pos32 < cnt32)) begin
          state_nxt = nei_pkg::S_RD_V;
        end else begin
          state_nxt = nei_pkg::S_RESP;
        end
      end
      nei_pkg::S_SCAN_RD: state_nxt = nei_pkg::S_SCAN_CMP;
      nei_pkg::S_SCAN_CMP: begin
        if (st_rdata_r == elem_r)                  state_nxt = nei_pkg::S_RESP;
        else if (32'(idx_r) + 32'd1 == cnt32)      state_nxt = nei_pkg::S_INS;
        else                                       state_nxt = nei_pkg::S_SCAN_RD;
      end
      nei_pkg::S_INS: begin
        if (32'(total_r) >= 32'(MAX_ENTRIES))      state_nxt = nei_pkg::S_RESP;
        else if (total_r > at_r)                   state_nxt = nei_pkg::S_SH_RD;
        else                                       state_nxt = nei_pkg::S_PUT;
      end
      nei_pkg::S_SH_RD: state_nxt = nei_pkg::S_SH_WR;
      nei_pkg::S_SH_WR: begin
        state_nxt = (32'(idx_r) - 32'd1 == 32'(at_r)) ? nei_pkg::S_PUT : nei_pkg::S_SH_RD;
      end
      nei_pkg::S_PUT:    state_nxt = nei_pkg::S_INC_RD;
      nei_pkg::S_INC_RD: state_nxt = nei_pkg::S_INC_WR;
      nei_pkg::S_INC_WR: begin
        state_nxt = (kidx_r == act) ? nei_pkg::S_RESP : nei_pkg::S_INC_RD;
      end
      nei_pkg::S_RD_V:  state_nxt = nei_pkg::S_RESP;
      nei_pkg::S_RESP: begin
        if (out_free) state_nxt = nei_pkg::S_IDLE;
      end
      default: state_nxt = nei_pkg::S_IDLE;
    endcase
    // a node_count write re-creates the table
    if (cfg_we) state_nxt = nei_pkg::S_CLR;
  end

  // memory controls and datapath
  always_comb begin
    off_we = 1'b0; off_re = 1'b0; off_waddr = '0; off_raddr = '0; off_wdata = '0;
    st_we  = 1'b0; st_re  = 1'b0; st_waddr  = '0; st_raddr  = '0; st_wdata  = '0;
    clr_resp_nxt = clr_resp_r;
    op_nxt = op_r; n_nxt = n_r; pos_nxt = pos_r; elem_nxt = elem_r;
    base_nxt = base_r; cnt_nxt = cnt_r; total_nxt = total_r; at_nxt = at_r;
    idx_nxt = idx_r; kidx_nxt = kidx_r; stat_nxt = stat_r; val_nxt = val_r;
    case (state_r)
      nei_pkg::S_CLR: begin
        off_we    = 1'b1;
        off_waddr = kidx_r;
        kidx_nxt  = kidx_r + NW'(1);
      end
      nei_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt   = in_if.opcode;
          pos_nxt  = in_if.position;
          elem_nxt = in_if.elem_number;
          n_nxt    = in_n32[NW-1:0];
          cnt_nxt  = '0;
          val_nxt  = '0;
          kidx_nxt = '0;
          clr_resp_nxt = 1'b1;
          stat_nxt = nei_pkg::ST_OK;
          if ((in_if.opcode != nei_pkg::OP_CLEAR) && in_bad_node) begin
            stat_nxt = nei_pkg::ST_BAD_NODE;
          end
          off_re    = 1'b1;
          off_raddr = NW'(in_n32 - 32'd1);
        end
      end
      nei_pkg::S_RD_B: begin
        base_nxt  = off_rdata_r;
        off_re    = 1'b1;
        off_raddr = n_r;
      end
      nei_pkg::S_RD_E: begin
        cnt_nxt   = off_rdata_r - base_r;
        off_re    = 1'b1;
        off_raddr = act;
      end
      nei_pkg::S_RD_T: begin
        total_nxt = off_rdata_r;
        at_nxt    = at32[OW-1:0];
      end
      nei_pkg::S_DECIDE: begin
        idx_nxt = '0;
        if (!insert_op) begin
          if ((op_r == nei_pkg::OP_SET) || (op_r == nei_pkg::OP_INSERT)
              || (op_r == nei_pkg::OP_READ)) begin
            if (pos32 < cnt32) begin
              if (op_r == nei_pkg::OP_SET) begin
                st_we    = 1'b1;
                st_waddr = at32[AW-1:0];
                st_wdata = elem_r;
              end else if (op_r == nei_pkg::OP_READ) begin
                st_re    = 1'b1;
                st_raddr = at32[AW-1:0];
              end
            end else begin
              stat_nxt = nei_pkg::ST_BAD_POS;
            end
          end
        end
      end
      nei_pkg::S_SCAN_RD: begin
        st_re    = 1'b1;
        st_raddr = AW'(32'(base_r) + 32'(idx_r));
      end
      nei_pkg::S_SCAN_CMP: begin
        idx_nxt = idx_r + OW'(1);
        if (st_rdata_r == elem_r) stat_nxt = nei_pkg::ST_DUP;
      end
      nei_pkg::S_INS: begin
        idx_nxt = total_r;
        if (32'(total_r) >= 32'(MAX_ENTRIES)) stat_nxt = nei_pkg::ST_FULL;
      end
      nei_pkg::S_SH_RD: begin
        st_re    = 1'b1;
        st_raddr = AW'(32'(idx_r) - 32'd1);
      end
      nei_pkg::S_SH_WR: begin
        st_we    = 1'b1;
        st_waddr = idx_r[AW-1:0];
        st_wdata = st_rdata_r;
        idx_nxt  = idx_r - OW'(1);
      end
      nei_pkg::S_PUT: begin
        st_we    = 1'b1;
        st_waddr = at_r[AW-1:0];
        st_wdata = elem_r;
        kidx_nxt = n_r;
      end
      nei_pkg::S_INC_RD: begin
        off_re    = 1'b1;
        off_raddr = kidx_r;
      end
      nei_pkg::S_INC_WR: begin
        off_we    = 1'b1;
        off_waddr = kidx_r;
        off_wdata = off_rdata_r + OW'(1);
        kidx_nxt  = kidx_r + NW'(1);
        if (kidx_r == act) cnt_nxt = cnt_r + OW'(1);
      end
      nei_pkg::S_RD_V: begin
        val_nxt = st_rdata_r;
      end
      default: ;
    endcase
    if (cfg_we) begin
      kidx_nxt     = '0;
      clr_resp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nei_pkg::S_CLR;
      node_count_r <= nei_pkg::NODE_COUNT_RST;
      clr_resp_r   <= 1'b0;
      kidx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_resp_r <= clr_resp_nxt;
      kidx_r     <= kidx_nxt;
      if (cfg_we) node_count_r <= cfg_wdata;
      if ((state_r == nei_pkg::S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; n_r <= n_nxt; pos_r <= pos_nxt; elem_r <= elem_nxt;
    base_r <= base_nxt; cnt_r <= cnt_nxt; total_r <= total_nxt; at_r <= at_nxt;
    idx_r <= idx_nxt; stat_r <= stat_nxt; val_r <= val_nxt;
    if ((state_r == nei_pkg::S_RESP) && out_free) begin
      out_stat_r <= stat_r;
      out_val_r  <= val_r;
      out_cnt_r  <= nei_pkg::POS_W'(cnt_r);
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_stat_r;
  assign out_if.elem_value = out_val_r;
  assign out_if.elem_count = out_cnt_r;

  // one item in flight
  `NEI_ASSERT(a_one_item, accept |=> !in_if.ready, "second item taken while busy")
  // no item enters during the zeroing pass
  `NEI_ASSERT_ALWAYS(a_clr_block, (state_r == nei_pkg::S_CLR) |-> !in_if.ready, "ready during clear")
  // store writes stay inside the store
  `NEI_ASSERT(a_st_addr, st_we |-> (32'(st_waddr) < 32'(MAX_ENTRIES)), "store write out of range")

endmodule
